// File: rtl/core/pba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
// ---------------------------------------------------------------------------
package pba_pkg;

  // Bitmap geometry
  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = MAX_PAGES / WORD_BITS;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int WADDR_W    = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);

  // Field widths
  localparam int MODE_W    = 3;
  localparam int INDEX_W   = 12;
  localparam int LEN_W     = 13;
  localparam int BYTE_W    = 48;
  localparam int STATUS_W  = 2;
  localparam int PCOUNT_W  = 13;

  // Frame numbers of a map entry, with room for the rounding carry
  localparam int FRAME_W = BYTE_W - PAGE_SHIFT + 1;
  localparam int END_W   = FRAME_W + 1;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(4096);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC_FIRST = 3'd0,
    MODE_CLAIM       = 3'd1,
    MODE_ALLOC_RUN   = 3'd2,
    MODE_FREE        = 3'd3,
    MODE_MARK_ALL    = 3'd4,
    MODE_MAP_ENTRY   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_RANGE     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SEARCH,
    ST_CLIP,
    ST_FILL,
    ST_DONE
  } state_e;

  // Bitmap memory access
  typedef struct packed {
    logic               re;
    logic [WADDR_W-1:0] raddr;
    logic               we;
    logic [WADDR_W-1:0] waddr;
    word_t              wdata;
  } mem_req_t;

  // Outcome of scanning one bitmap word
  typedef struct packed {
    logic             hit;
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0]  carry_out;
  } scan_res_t;

endpackage

// File: rtl/core/pba_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_if
// Valid/ready channels of the page bitmap allocator: request, response and
// page count write.
// ---------------------------------------------------------------------------
interface pba_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [11:0] target_page;
  logic [12:0] run_length;
  logic [47:0] region_base;
  logic [47:0] region_size;
  logic        region_reserved;

  modport source (output valid, mode, target_page, run_length, region_base,
                  region_size, region_reserved, input ready);
  modport sink   (input valid, mode, target_page, run_length, region_base,
                  region_size, region_reserved, output ready);
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] result_index;

  modport source (output valid, status, result_index, input ready);
  modport sink   (input valid, status, result_index, output ready);
endinterface

interface pba_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] page_count;

  modport source (output valid, page_count, input ready);
  modport sink   (input valid, page_count, output ready);
endinterface

// File: rtl/core/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap page frame allocator: one used bit per page in a 64 x 64 word
// memory, searched and updated one word per cycle.
// ---------------------------------------------------------------------------
// Flow: a request is captured, set up, searched (modes 0/2) word by word,
//   clipped to the page count, then filled word by word before the response.
//   Claim/free of one page skips the search; a failed search skips the fill.
// Throughput: one request at a time, limited by the word-serial memory port.
// Reset: bitmap reads as all used at once (per-word written flags), page
//   count returns to 4096; no clearing pass.
// ---------------------------------------------------------------------------
module page_bitmap_allocator (
  input  logic      clk,
  input  logic      rst,
  pba_req_if.sink   req,
  pba_rsp_if.source rsp,
  pba_cfg_if.sink   cfg
);
  import pba_pkg::*;

  state_e state, state_next;

  // Configuration
  logic [PCOUNT_W-1:0] page_count;
  logic [CNT_W-1:0]    eff_count;

  // Captured request
  logic [MODE_W-1:0]  r_mode;
  logic [INDEX_W-1:0] r_idx;
  logic [LEN_W-1:0]   r_len;
  logic [BYTE_W-1:0]  r_base;
  logic [BYTE_W-1:0]  r_size;
  logic               r_resv;

  // Range and scan bookkeeping
  logic [FRAME_W-1:0] rng_start;
  logic [FRAME_W-1:0] rng_n;
  logic               rng_set;
  logic [PAGE_W-1:0]  fill_lo;
  logic [PAGE_W-1:0]  fill_hi;
  logic [WADDR_W:0]   rd_ptr;
  logic               pend;
  logic [WADDR_W-1:0] dw;
  logic [CNT_W-1:0]   carry;
  logic [CNT_W-1:0]   need;

  // Result
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [INDEX_W-1:0]  rsp_index;

  mem_req_t  mreq;
  word_t     rdata;
  scan_res_t scan;

  // Combinational helpers
  logic [CNT_W-1:0]   setup_need;
  logic               idx_ok;
  logic [FRAME_W-1:0] map_start;
  logic [FRAME_W-1:0] map_n;
  logic [END_W-1:0]   end_full;
  logic [CNT_W-1:0]   end_clip;
  logic               rng_empty;
  logic [PAGE_W-1:0]  end_m1;
  logic               rd_more;
  word_t              lo_mask;
  word_t              hi_mask;
  word_t              fmask;
  logic               out_free;

  pba_bitmap_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (rdata)
  );

  pba_word_scan u_scan (
    .word      (rdata),
    .word_idx  (dw),
    .eff_count (eff_count),
    .carry_in  (carry),
    .need      (need),
    .res       (scan)
  );

  assign eff_count = (page_count > PCOUNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                         : CNT_W'(page_count);
  assign out_free  = !rsp_valid || rsp.ready;

  // Request decode helpers
  always_comb begin
    logic [FRAME_W-2:0] pg_base;
    logic [FRAME_W-2:0] pg_size;
    logic               base_off;
    logic               size_off;
    pg_base  = r_base[BYTE_W-1:PAGE_SHIFT];
    pg_size  = r_size[BYTE_W-1:PAGE_SHIFT];
    base_off = |r_base[PAGE_SHIFT-1:0];
    size_off = |r_size[PAGE_SHIFT-1:0];
    setup_need = (r_mode == MODE_ALLOC_FIRST) ? CNT_W'(1) : CNT_W'(r_len);
    idx_ok     = CNT_W'(r_idx) < eff_count;
    if (r_resv) begin
      map_start = {1'b0, pg_base};
      map_n     = {1'b0, pg_size} + FRAME_W'(size_off);
    end else if (base_off) begin
      map_start = {1'b0, pg_base} + FRAME_W'(1);
      map_n     = (pg_size == '0) ? '0 : ({1'b0, pg_size} - FRAME_W'(1));
    end else begin
      map_start = {1'b0, pg_base};
      map_n     = {1'b0, pg_size};
    end
  end

  // Range end, clipped to the page count
  always_comb begin
    end_full  = {1'b0, rng_start} + {1'b0, rng_n};
    end_clip  = (end_full > END_W'(eff_count)) ? eff_count : end_full[CNT_W-1:0];
    rng_empty = END_W'(rng_start) >= END_W'(end_clip);
  end

  // Fill mask for the word now arriving
  always_comb begin
    end_m1  = fill_hi;
    lo_mask = (dw == fill_lo[PAGE_W-1:BIT_W]) ? ('1 << fill_lo[BIT_W-1:0]) : '1;
    hi_mask = (dw == end_m1[PAGE_W-1:BIT_W])
              ? ('1 >> (BIT_W'(WORD_BITS - 1) - end_m1[BIT_W-1:0])) : '1;
    fmask   = lo_mask & hi_mask;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        priority case (r_mode)
          MODE_ALLOC_FIRST, MODE_ALLOC_RUN:
            state_next = (setup_need == '0) ? ST_DONE : ST_SEARCH;
          MODE_CLAIM, MODE_FREE:
            state_next = idx_ok ? ST_CLIP : ST_DONE;
          MODE_MARK_ALL, MODE_MAP_ENTRY:
            state_next = ST_CLIP;
          default:
            state_next = ST_DONE;
        endcase
      end
      ST_SEARCH: begin
        if (pend && scan.hit) begin
          state_next = ST_CLIP;
        end else if (pend && dw == WADDR_W'(WORD_COUNT - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_CLIP: begin
        state_next = rng_empty ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        if (pend && dw == fill_hi[PAGE_W-1:BIT_W]) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port and handshake outputs
  always_comb begin
    rd_more     = (state == ST_SEARCH) ? !rd_ptr[WADDR_W]
                                       : (rd_ptr <= {1'b0, fill_hi[PAGE_W-1:BIT_W]});
    mreq.re     = (state == ST_SEARCH || state == ST_FILL) && rd_more;
    mreq.raddr  = rd_ptr[WADDR_W-1:0];
    mreq.we     = (state == ST_FILL) && pend;
    mreq.waddr  = dw;
    mreq.wdata  = rng_set ? (rdata | fmask) : (rdata & ~fmask);
    req.ready   = (state == ST_IDLE);
    cfg.ready   = 1'b1;
  end

  // Page count register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= PCOUNT_RESET;
    end else if (cfg.valid) begin
      page_count <= cfg.page_count;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      r_mode <= req.mode;
      r_idx  <= req.target_page;
      r_len  <= req.run_length;
      r_base <= req.region_base;
      r_size <= req.region_size;
      r_resv <= req.region_reserved;
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      rd_ptr     <= '0;
      res_status <= STAT_OK;
      res_index  <= '0;
    end else begin
      state <= state_next;
      pend  <= mreq.re;
      if (mreq.re) begin
        rd_ptr <= rd_ptr + (WADDR_W+1)'(1);
        dw     <= rd_ptr[WADDR_W-1:0];
      end
      unique case (state)
        ST_IDLE: begin
          res_status <= STAT_OK;
          res_index  <= '0;
        end
        ST_SETUP: begin
          rd_ptr <= '0;
          carry  <= '0;
          need   <= setup_need;
          priority case (r_mode)
            MODE_ALLOC_FIRST, MODE_ALLOC_RUN: begin
              if (setup_need == '0) res_status <= STAT_NOT_FOUND;
            end
            MODE_CLAIM, MODE_FREE: begin
              rng_start <= FRAME_W'(r_idx);
              rng_n     <= FRAME_W'(1);
              rng_set   <= (r_mode == MODE_CLAIM);
              if (!idx_ok) begin
                res_status <= STAT_RANGE;
              end else if (r_mode == MODE_CLAIM) begin
                res_index <= r_idx;
              end
            end
            MODE_MARK_ALL: begin
              rng_start <= '0;
              rng_n     <= FRAME_W'(eff_count);
              rng_set   <= 1'b1;
            end
            MODE_MAP_ENTRY: begin
              rng_start <= map_start;
              rng_n     <= map_n;
              rng_set   <= r_resv;
            end
            default: ;
          endcase
        end
        ST_SEARCH: begin
          if (pend) begin
            carry <= scan.carry_out;
            if (scan.hit) begin
              rng_start <= FRAME_W'(scan.first);
              rng_n     <= FRAME_W'(need);
              rng_set   <= 1'b1;
              res_index <= INDEX_W'(scan.first);
            end else if (dw == WADDR_W'(WORD_COUNT - 1)) begin
              res_status <= STAT_NOT_FOUND;
            end
          end
        end
        ST_CLIP: begin
          fill_lo <= rng_start[PAGE_W-1:0];
          fill_hi <= PAGE_W'(end_clip - CNT_W'(1));
          rd_ptr  <= {1'b0, rng_start[PAGE_W-1:BIT_W]};
        end
        ST_FILL, ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp_status <= res_status;
      rsp_index  <= res_index;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.result_index = rsp_index;

  // Bitmap is written only while filling a range
  a_write_in_fill: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (state == ST_FILL))
    else $error("bitmap written outside a fill");

  // Writes stay inside the words of the clipped range
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (mreq.waddr >= fill_lo[PAGE_W-1:BIT_W]
                 && mreq.waddr <= fill_hi[PAGE_W-1:BIT_W]))
    else $error("bitmap write outside the range");

  // A failed request reports page zero
  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != STAT_OK) |-> (rsp_index == '0))
    else $error("failed request carries a page index");

  // A new response is loaded only from the done state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("response raised outside the done state");

endmodule

// File: rtl/core/pba_bitmap_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_bitmap_mem
// Bitmap word store: one write and one read port, registered read data.
// Words never written since reset read as all ones (every page used).
// ---------------------------------------------------------------------------
module pba_bitmap_mem (
  input  logic              clk,
  input  logic              rst,
  input  pba_pkg::mem_req_t req,
  output pba_pkg::word_t    rdata
);
  import pba_pkg::*;

  word_t                 mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] written;
  word_t                 rd_word;
  logic                  rd_written;

  // Storage array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_word <= mem[req.raddr];
    end
  end

  // Per-word written flags stand in for the all-ones reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_written <= written[req.raddr];
      end
    end
  end

  assign rdata = rd_written ? rd_word : '1;

  // No same-word read and write in one cycle: the controller never needs it
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (req.re && req.we) |-> (req.raddr != req.waddr))
    else $error("bitmap read and write hit the same word");

endmodule

// File: rtl/core/pba_word_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_word_scan
// Free-run search over one bitmap word, continuing the run carried in from
// the words below. Pages at or above the page count count as used.
// ---------------------------------------------------------------------------
module pba_word_scan (
  input  pba_pkg::word_t                    word,
  input  logic [pba_pkg::WADDR_W-1:0]       word_idx,
  input  logic [pba_pkg::CNT_W-1:0]         eff_count,
  input  logic [pba_pkg::CNT_W-1:0]         carry_in,
  input  logic [pba_pkg::CNT_W-1:0]         need,
  output pba_pkg::scan_res_t                res
);
  import pba_pkg::*;

  word_t              used;
  word_t              has_lv [BIT_W+1];
  logic [BIT_W-1:0]   pos_lv [BIT_W+1][WORD_BITS];
  logic [CNT_W-1:0]   run_len [WORD_BITS];
  word_t              match;

  // Mask out pages beyond the tracked count
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      used[k] = word[k] | ({1'b0, word_idx, BIT_W'(k)} >= eff_count);
    end
  end

  // Prefix scan: highest used bit at or below each position
  always_comb begin
    has_lv[0] = used;
    for (int k = 0; k < WORD_BITS; k++) begin
      pos_lv[0][k] = BIT_W'(k);
    end
    for (int s = 0; s < BIT_W; s++) begin
      for (int k = 0; k < WORD_BITS; k++) begin
        if (k >= (1 << s) && !has_lv[s][k]) begin
          has_lv[s+1][k] = has_lv[s][k - (1 << s)];
          pos_lv[s+1][k] = pos_lv[s][k - (1 << s)];
        end else begin
          has_lv[s+1][k] = has_lv[s][k];
          pos_lv[s+1][k] = pos_lv[s][k];
        end
      end
    end
  end

  // Run length ending at each free bit, and the match vector
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      if (has_lv[BIT_W][k]) begin
        run_len[k] = CNT_W'(BIT_W'(k) - pos_lv[BIT_W][k]);
      end else begin
        run_len[k] = carry_in + CNT_W'(k) + CNT_W'(1);
      end
      match[k] = !used[k] && (run_len[k] >= need);
    end
  end

  // Lowest matching position and the run handed to the next word
  always_comb begin
    logic [BIT_W-1:0] hit_pos;
    logic [CNT_W-1:0] end_page;
    hit_pos = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_pos = BIT_W'(k);
      end
    end
    end_page  = {1'b0, word_idx, hit_pos} + CNT_W'(1) - need;
    res.hit   = |match;
    res.first = end_page[PAGE_W-1:0];
    if (has_lv[BIT_W][WORD_BITS-1]) begin
      res.carry_out = CNT_W'(BIT_W'(WORD_BITS - 1) - pos_lv[BIT_W][WORD_BITS-1]);
    end else begin
      res.carry_out = carry_in + CNT_W'(WORD_BITS);
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for page_bitmap_allocator. A directed table with
// hand-read answers, then random request phases over several page counts;
// the rest is checked against a bitmap predictor held in the bench. Both
// channels idle in random bursts; one long response hold-off fills the block.
// ---------------------------------------------------------------------------
module tb;
  import pba_pkg::*;

  localparam int          LIMIT_CYCLES   = 1_000_000;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          N_DIR          = 30;
  localparam int          N_PHASES       = 8;
  localparam int          PRESSURE_PHASE = 3;
  localparam int          MAX_REPORTS    = 10;
  // Mode codes the block must treat as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [BYTE_W-1:0] BYTES_ALL     = {BYTE_W{1'b1}};

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] page;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  base;
    logic [BYTE_W-1:0]  size;
    logic               rsv;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
  } outcome_t;

  // One row of the directed table: a page count write, or a request with an
  // optional hand-read answer
  typedef struct {
    bit                  cfg;
    logic [PCOUNT_W-1:0] count;
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  page;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   base;
    logic [BYTE_W-1:0]   size;
    logic                rsv;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  pba_req_if req_if ();
  pba_rsp_if rsp_if ();
  pba_cfg_if cfg_if ();

  page_bitmap_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // Predictor state
  logic [MAX_PAGES-1:0] page_used;
  logic [PCOUNT_W-1:0]  tracked_count;
  outcome_t             pending_outcomes [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  tail_mode      = 1'b0;
  bit  hold_request   = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    // everything used after reset
    '{0, 0, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 1, STAT_NOT_FOUND, 0},
    '{0, 0, MODE_ALLOC_RUN, 0, 1, 0, 0, 0, 1, STAT_NOT_FOUND, 0},
    // claim of an already used page, top and bottom
    '{0, 0, MODE_CLAIM, 12'd4095, 0, 0, 0, 0, 1, STAT_OK, 12'd4095},
    '{0, 0, MODE_CLAIM, 0, 0, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_MAP_ENTRY, 0, 0, 0, 48'h1_0000, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 0, STAT_OK, 0},
    // zero run and run longer than the map
    '{0, 0, MODE_ALLOC_RUN, 0, 0, 0, 0, 0, 1, STAT_NOT_FOUND, 0},
    '{0, 0, MODE_ALLOC_RUN, 0, 8, 0, 0, 0, 0, STAT_OK, 0},
    '{0, 0, MODE_ALLOC_RUN, 0, 13'd8191, 0, 0, 0, 1, STAT_NOT_FOUND, 0},
    '{0, 0, MODE_FREE, 12'd4095, 0, 0, 0, 0, 1, STAT_OK, 0},
    // misaligned usable entry loses a page; tiny one frees nothing
    '{0, 0, MODE_MAP_ENTRY, 0, 0, 48'h20_0800, 48'h5000, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_MAP_ENTRY, 0, 0, 48'h1, 48'h800, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_MAP_ENTRY, 0, 0, 48'h20_2000, 48'h1001, 1, 1, STAT_OK, 0},
    // extreme entries, clipped to the page count
    '{0, 0, MODE_MAP_ENTRY, 0, 0, BYTES_ALL, BYTES_ALL, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_MAP_ENTRY, 0, 0, 0, BYTES_ALL, 1, 1, STAT_OK, 0},
    '{0, 0, MODE_MAP_ENTRY, 0, 0, 0, BYTES_ALL, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_ALLOC_RUN, 0, 13'd4096, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_SPARE_LO, 0, 0, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_SPARE_HI, 0, 0, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_FREE, 12'd100, 0, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 0, STAT_OK, 0},
    '{0, 0, MODE_MARK_ALL, 0, 0, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 1, STAT_NOT_FOUND, 0},
    // zero page count: every index out of range
    '{1, 0, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 0, STAT_OK, 0},
    '{0, 0, MODE_CLAIM, 0, 0, 0, 0, 0, 1, STAT_RANGE, 0},
    '{0, 0, MODE_FREE, 12'd4095, 0, 0, 0, 0, 1, STAT_RANGE, 0},
    // single page
    '{1, 1, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 0, STAT_OK, 0},
    '{0, 0, MODE_FREE, 0, 0, 0, 0, 0, 1, STAT_OK, 0},
    '{0, 0, MODE_CLAIM, 12'd1, 0, 0, 0, 0, 1, STAT_RANGE, 0},
    '{0, 0, MODE_ALLOC_FIRST, 0, 0, 0, 0, 0, 0, STAT_OK, 0}
  };

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Bitmap predictor
  // ---------------------------------------------------------------------
  function automatic int unsigned eff_pages();
    return (tracked_count < PCOUNT_W'(MAX_PAGES)) ? int'(tracked_count) : MAX_PAGES;
  endfunction

  function automatic void mark_range(longint unsigned start, longint unsigned n, bit v);
    longint unsigned stop;
    stop = start + n;
    if (stop > eff_pages())
      stop = eff_pages();
    for (longint unsigned i = start; i < stop; i++)
      page_used[int'(i)] = v;
  endfunction

  // Lowest start of n free pages in a row
  function automatic bit find_free_run(longint unsigned n, output longint unsigned first);
    longint unsigned run;
    run   = 0;
    first = 0;
    if (n == 0)
      return 1'b0;
    for (int i = 0; i < int'(eff_pages()); i++) begin
      if (page_used[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == n) begin
          first = longint'(i) + 1 - n;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic outcome_t predict_request(request_t r);
    outcome_t        o;
    longint unsigned first;
    longint unsigned n;
    o.status = STAT_OK;
    o.index  = '0;
    case (r.mode)
      MODE_ALLOC_FIRST: begin
        if (find_free_run(1, first)) begin
          page_used[int'(first)] = 1'b1;
          o.index = INDEX_W'(first);
        end else begin
          o.status = STAT_NOT_FOUND;
        end
      end
      MODE_CLAIM: begin
        if (r.page < eff_pages()) begin
          page_used[r.page] = 1'b1;
          o.index = r.page;
        end else begin
          o.status = STAT_RANGE;
        end
      end
      MODE_ALLOC_RUN: begin
        if (find_free_run(r.len, first)) begin
          mark_range(first, r.len, 1'b1);
          o.index = INDEX_W'(first);
        end else begin
          o.status = STAT_NOT_FOUND;
        end
      end
      MODE_FREE: begin
        if (r.page < eff_pages())
          page_used[r.page] = 1'b0;
        else
          o.status = STAT_RANGE;
      end
      MODE_MARK_ALL: mark_range(0, eff_pages(), 1'b1);
      MODE_MAP_ENTRY: begin
        n = r.size >> PAGE_SHIFT;
        if (r.rsv) begin
          // reserved: end rounded up to a whole page
          mark_range(r.base >> PAGE_SHIFT, n + (|r.size[PAGE_SHIFT-1:0]), 1'b1);
        end else if (|r.base[PAGE_SHIFT-1:0]) begin
          // usable, misaligned: start rounded up, one page fewer
          mark_range((r.base >> PAGE_SHIFT) + 1, (n != 0) ? n - 1 : 0, 1'b0);
        end else begin
          mark_range(r.base >> PAGE_SHIFT, n, 1'b0);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Random requests, mostly aimed inside the tracked range
  // ---------------------------------------------------------------------
  function automatic request_t random_request(int unsigned lim);
    request_t          r;
    int unsigned       pick;
    int unsigned       sel;
    int unsigned       pages;
    logic [BYTE_W-1:0] off;
    r.mode = MODE_ALLOC_FIRST;
    r.page = INDEX_W'($urandom);
    r.len  = LEN_W'($urandom);
    r.base = {16'($urandom), 32'($urandom)};
    r.size = {16'($urandom), 32'($urandom)};
    r.rsv  = 1'($urandom);
    pick   = $urandom_range(0, 99);
    sel    = $urandom_range(0, 9);
    if (pick < 26) begin
      r.mode = MODE_MAP_ENTRY;
      r.rsv  = (pick >= 18);
      off    = ($urandom_range(0, 1) == 0) ? '0 : BYTE_W'(12'($urandom));
      r.base = (BYTE_W'($urandom_range(0, lim + 4)) << PAGE_SHIFT) | off;
      pages  = (sel == 0) ? $urandom_range(0, lim + 2) : $urandom_range(0, 48);
      off    = ($urandom_range(0, 1) == 0) ? '0 : BYTE_W'(12'($urandom));
      r.size = (BYTE_W'(pages) << PAGE_SHIFT) | off;
    end else if (pick < 42) begin
      r.mode = MODE_FREE;
      if (sel != 0)
        r.page = INDEX_W'($urandom_range(0, lim + 3));
    end else if (pick < 58) begin
      r.mode = MODE_ALLOC_FIRST;
    end else if (pick < 68) begin
      r.mode = MODE_CLAIM;
      if (sel != 0)
        r.page = INDEX_W'($urandom_range(0, lim + 3));
    end else if (pick < 88) begin
      r.mode = MODE_ALLOC_RUN;
      sel    = $urandom_range(0, 99);
      if (sel < 70)
        r.len = LEN_W'($urandom_range(1, 8));
      else if (sel < 90)
        r.len = LEN_W'($urandom_range(1, 64));
      else if (sel < 98)
        r.len = LEN_W'($urandom_range(1, lim + 1));
    end else if (pick < 90) begin
      r.mode = MODE_MARK_ALL;
    end else if (pick < 93) begin
      r.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
    end else begin
      // map entry with raw 48-bit fields
      r.mode = MODE_MAP_ENTRY;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------
  // Offer one request and hold it until transfer; valid is left high
  task automatic offer_request(request_t r, bit typed, logic [STATUS_W-1:0] st,
                               logic [INDEX_W-1:0] ix);
    outcome_t o;
    req_if.valid           <= 1'b1;
    req_if.mode            <= r.mode;
    req_if.target_page     <= r.page;
    req_if.run_length      <= r.len;
    req_if.region_base     <= r.base;
    req_if.region_size     <= r.size;
    req_if.region_reserved <= r.rsv;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    o = predict_request(r);
    if (typed) begin
      o.status = st;
      o.index  = ix;
    end
    pending_outcomes.push_back(o);
  endtask

  // Random sender gap after a transfer
  task automatic req_pause();
    int unsigned n;
    if (!tail_mode && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Page count write, only once every response is back
  task automatic write_page_count(logic [PCOUNT_W-1:0] v);
    while (pending_outcomes.size() != 0) @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.page_count <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid  <= 1'b0;
    tracked_count = v;
  endtask

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------
  // Response sink: random stall bursts, one long hold-off, none at the end
  // ---------------------------------------------------------------------
  initial begin : rsp_ready_driver
    int unsigned n;
    rsp_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (tail_mode) begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end else if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 30);
        rsp_ready_on: begin
          rsp_if.ready <= 1'b1;
          repeat (n) @(posedge clk);
        end
        n = $urandom_range(1, 17);
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Compare each response transfer with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        log_mismatch($sformatf("unexpected response: status %0d index %0d",
                               rsp_if.status, rsp_if.result_index));
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_if.status !== want.status || rsp_if.result_index !== want.index)
          log_mismatch($sformatf("response: expected status %0d index %0d, got %0d %0d",
                                 want.status, want.index, rsp_if.status,
                                 rsp_if.result_index));
      end
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("page_bitmap_allocator: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    request_t            r;
    logic [PCOUNT_W-1:0] phase_counts [N_PHASES];
    int unsigned         n_items;
    req_if.valid           = 1'b0;
    req_if.mode            = '0;
    req_if.target_page     = '0;
    req_if.run_length      = '0;
    req_if.region_base     = '0;
    req_if.region_size     = '0;
    req_if.region_reserved = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.page_count      = '0;
    page_used              = '1;
    tracked_count          = PCOUNT_RESET;

    phase_counts = '{13'd4096, 13'd8191, 13'd1, 13'd200, 13'd0,
                     PCOUNT_W'($urandom_range(2, 4095)), 13'd64, 13'd4096};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].cfg) begin
        req_if.valid <= 1'b0;
        write_page_count(dir_rows[i].count);
      end else begin
        r.mode = dir_rows[i].mode;
        r.page = dir_rows[i].page;
        r.len  = dir_rows[i].len;
        r.base = dir_rows[i].base;
        r.size = dir_rows[i].size;
        r.rsv  = dir_rows[i].rsv;
        offer_request(r, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].index);
        req_pause();
      end
    end

    // Random phases, one page count each
    for (int p = 0; p < N_PHASES; p++) begin
      req_if.valid <= 1'b0;
      write_page_count(phase_counts[p]);
      if (p == N_PHASES - 1)
        tail_mode = 1'b1;
      if (p == PRESSURE_PHASE)
        hold_request = 1'b1;
      n_items = (eff_pages() <= 1) ? 50 : 170;
      for (int k = 0; k < int'(n_items); k++) begin
        offer_request(random_request(eff_pages()), 1'b0, STAT_OK, '0);
        // back-to-back during the hold-off so the block backs up
        if (!(p == PRESSURE_PHASE && k < 40))
          req_pause();
      end
    end
    req_if.valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("page_bitmap_allocator: match");
    else
      $display("page_bitmap_allocator: mismatch");
    $finish;
  end

endmodule
